// ----- hdl/gadc_pkg.sv -----
// Package for the gamepad axis deadzone conditioner: beat payload types,
// register map, lane load type and shared constants.
// No dependencies; compile first.
package gadc_pkg;

   // Register map: index taken from paddr[3:2]
   localparam int ADDR_W = 4;
   localparam logic [1:0] REG_LEFT_DZ  = 2'd0;
   localparam logic [1:0] REG_RIGHT_DZ = 2'd1;
   localparam logic [1:0] REG_TRIG_DZ  = 2'd2;

   localparam logic [14:0] LEFT_DZ_RESET  = 15'd15698;
   localparam logic [14:0] RIGHT_DZ_RESET = 15'd17378;
   localparam logic [7:0]  TRIG_DZ_RESET  = 8'd60;

   // Full-scale figures and the button mask
   localparam logic [16:0] STICK_FULL = 17'd32768;
   localparam logic [7:0]  TRIG_FULL  = 8'd255;
   localparam logic [15:0] BTN_MASK   = 16'hF3FF;

   // Divider steps after the leading quotient bit
   localparam int STEP_COUNT = 15;
   localparam int CNT_W      = 4;

   typedef struct packed {
      logic               poll_valid;
      logic [15:0]        raw_buttons;
      logic signed [15:0] left_stick_x;
      logic signed [15:0] left_stick_y;
      logic signed [15:0] right_stick_x;
      logic signed [15:0] right_stick_y;
      logic [7:0]         left_trigger;
      logic [7:0]         right_trigger;
   } req_payload_type;

   typedef struct packed {
      logic               pad_present;
      logic [25:0]        pressed_now;
      logic [25:0]        pressed_before;
      logic signed [15:0] left_x_scaled;
      logic signed [15:0] left_y_scaled;
      logic signed [15:0] right_x_scaled;
      logic signed [15:0] right_y_scaled;
      logic [15:0]        left_trigger_scaled;
      logic [15:0]        right_trigger_scaled;
   } rsp_payload_type;

   typedef struct packed {
      logic [14:0] left_dz;
      logic [14:0] right_dz;
      logic [7:0]  trig_dz;
   } cfg_type;

   // Operands handed to one divider lane at the start of a poll
   typedef struct packed {
      logic [15:0] mag;
      logic [15:0] den;
      logic        neg;
   } lane_load_type;

   // Per-poll control travelling from the sequencer to the merge stage
   typedef struct packed {
      logic        poll_valid;
      logic [15:0] buttons;
      logic [9:0]  derived;
   } job_type;

endpackage

// ----- hdl/gadc_if.sv -----
// Valid/ready channel interfaces for poll beats and result beats.
// Depends on gadc_pkg.
interface gadc_req_if;
   import gadc_pkg::*;
   logic            valid;
   logic            ready;
   req_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface gadc_rsp_if;
   import gadc_pkg::*;
   logic            valid;
   logic            ready;
   rsp_payload_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/gadc_csr.sv -----
// APB-style register block holding the three deadzone registers.
// Depends on gadc_pkg.
module gadc_csr
   import gadc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output cfg_type           cfg
);

   cfg_type    cfg_ff, cfg_in;
   logic [1:0] idx;
   logic       wr_en;

   assign idx    = paddr[3:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   // Decode the write; keep only the low bits of each register
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_LEFT_DZ:  cfg_in.left_dz  = pwdata[14:0];
            REG_RIGHT_DZ: cfg_in.right_dz = pwdata[14:0];
            REG_TRIG_DZ:  cfg_in.trig_dz  = pwdata[7:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.left_dz  <= LEFT_DZ_RESET;
         cfg_ff.right_dz <= RIGHT_DZ_RESET;
         cfg_ff.trig_dz  <= TRIG_DZ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (idx)
         REG_LEFT_DZ:  prdata = {17'd0, cfg_ff.left_dz};
         REG_RIGHT_DZ: prdata = {17'd0, cfg_ff.right_dz};
         REG_TRIG_DZ:  prdata = {24'd0, cfg_ff.trig_dz};
         default:      prdata = 32'd0;
      endcase
   end

endmodule

// ----- hdl/gadc_lane.sv -----
// One divider lane: restoring division of mag*32768 by den, one quotient
// bit a cycle while step is high; sign at output. Depends on gadc_pkg.
module gadc_lane
   import gadc_pkg::*;
(
   input  logic          clock,
   input  logic          start,
   input  logic          step,
   input  lane_load_type load,
   output logic [15:0]   scaled
);

   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic [16:0] rem_dbl;
   logic [16:0] rem_sub;
   logic        first_ge;
   logic        step_ge;

   assign first_ge = load.mag >= load.den;
   assign rem_dbl  = {rem_ff, 1'b0};
   assign rem_sub  = rem_dbl - {1'b0, den_ff};
   assign step_ge  = rem_dbl >= {1'b0, den_ff};

   // Load the leading bit on start, then shift one bit in per step
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      den_in = den_ff;
      neg_in = neg_ff;
      if (start) begin
         rem_in = first_ge ? (load.mag - load.den) : load.mag;
         quo_in = {15'd0, first_ge};
         den_in = load.den;
         neg_in = load.neg;
      end else if (step) begin
         rem_in = step_ge ? rem_sub[15:0] : rem_dbl[15:0];
         quo_in = {quo_ff[14:0], step_ge};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign scaled = neg_ff ? (16'd0 - quo_ff) : quo_ff;

endmodule

// ----- hdl/gadc_merge.sv -----
// Merge stage: gathers the lane results and derived bits into a result
// beat, holds the previous pressed vector. Depends on gadc_pkg, gadc_if.
module gadc_merge
   import gadc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  job_type     job,
   input  logic [15:0] lane_lx,
   input  logic [15:0] lane_ly,
   input  logic [15:0] lane_rx,
   input  logic [15:0] lane_ry,
   input  logic [15:0] lane_lt,
   input  logic [15:0] lane_rt,
   gadc_rsp_if.source  rsp
);

   rsp_payload_type data_ff, data_in;
   logic [25:0]     stored_ff, stored_in;
   logic            valid_ff, valid_in;
   logic [25:0]     now;

   assign now = {job.derived, job.buttons & BTN_MASK};

   // Build the beat; an absent pad clears everything
   always_comb begin
      data_in   = data_ff;
      stored_in = stored_ff;
      if (load) begin
         if (job.poll_valid) begin
            data_in.pad_present          = 1'b1;
            data_in.pressed_now          = now;
            data_in.pressed_before       = stored_ff;
            data_in.left_x_scaled        = lane_lx;
            data_in.left_y_scaled        = lane_ly;
            data_in.right_x_scaled       = lane_rx;
            data_in.right_y_scaled       = lane_ry;
            data_in.left_trigger_scaled  = lane_lt;
            data_in.right_trigger_scaled = lane_rt;
            stored_in                    = now;
         end else begin
            data_in   = '0;
            stored_in = '0;
         end
      end
   end

   // Hold the beat until taken
   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         stored_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         stored_ff <= stored_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp.valid = valid_ff;
   assign rsp.data  = data_ff;

endmodule

// ----- hdl/gamepad_axis_deadzone_conditioner.sv -----
// Gamepad axis deadzone conditioner: one poll beat in, one result beat out.
// Depends on gadc_pkg, gadc_if, gadc_csr, gadc_lane, gadc_merge.
//
// Usage
//   req carries one controller poll per beat; rsp returns one conditioned
//   result beat per poll, in order. The deadzone registers sit on the APB
//   port at byte addresses 0, 4 and 8; the user must write them only while
//   the block idles, and the block itself does not enforce this. Six divider
//   lanes (four stick axes, two triggers) run side by side, each producing
//   one quotient bit a cycle; the 16-bit quotient sets the timing. The lanes
//   load at the accepting edge, take the divider steps in ST_RUN, and the
//   merge stage registers the result beat in ST_DONE and raises rsp.valid.
//   req.ready is high only while the lanes are free; the result register
//   parts the two sides, so the next poll may be accepted while a result
//   waits. If the receiver stalls, the lanes finish and wait for the result
//   register to empty, and no further poll is taken until then.
//   Reset is synchronous: it empties the result register, clears the stored
//   pressed vector and restores the register reset values.
module gamepad_axis_deadzone_conditioner
   import gadc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   gadc_req_if.sink          req,
   gadc_rsp_if.source        rsp,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   typedef struct packed {
      lane_load_type load;
      logic          hi;
      logic          lo;
   } stick_prep_type;

   typedef struct packed {
      lane_load_type load;
      logic          half;
   } trig_prep_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   job_type          job_ff, job_in;
   cfg_type          cfg;
   logic             accept;
   logic             step;
   logic             load_out;
   logic             out_free;
   stick_prep_type   p_lx, p_ly, p_rx, p_ry;
   trig_prep_type    p_lt, p_rt;
   logic [15:0]      s_lx, s_ly, s_rx, s_ry, s_lt, s_rt;

   // Stick axis: deadzone test, divider operands and half-deflection flags
   function automatic stick_prep_type stick_prep(input logic [15:0] v, input logic [14:0] d);
      stick_prep_type     r;
      logic signed [16:0] vs;
      logic signed [16:0] ds;
      logic signed [16:0] num_p;
      logic signed [16:0] mag_n;
      logic               pos;
      logic               negc;
      logic [15:0]        den;
      vs    = {v[15], v};
      ds    = {2'b00, d};
      pos   = vs > ds;
      negc  = vs < -ds;
      num_p = vs - ds;
      mag_n = -vs - ds;
      den   = 16'(STICK_FULL - {2'b00, d});
      r.load.den = den;
      r.load.neg = negc;
      r.load.mag = pos ? num_p[15:0] : (negc ? mag_n[15:0] : 16'd0);
      r.hi = pos  && ({num_p[15:0], 1'b0} > {1'b0, den});
      r.lo = negc && ({mag_n[15:0], 1'b0} > {1'b0, den});
      return r;
   endfunction

   // Trigger: a deadzone of full scale never passes
   function automatic trig_prep_type trig_prep(input logic [7:0] v, input logic [7:0] t);
      trig_prep_type r;
      logic          act;
      logic [7:0]    den;
      logic [7:0]    num;
      act = (t != TRIG_FULL) && (v >= t);
      den = (t == TRIG_FULL) ? 8'd1 : (TRIG_FULL - t);
      num = v - t;
      r.load.den = {8'd0, den};
      r.load.neg = 1'b0;
      r.load.mag = act ? {8'd0, num} : 16'd0;
      r.half = act && ({num, 1'b0} > {1'b0, den});
      return r;
   endfunction

   gadc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign p_lx = stick_prep(req.data.left_stick_x,  cfg.left_dz);
   assign p_ly = stick_prep(req.data.left_stick_y,  cfg.left_dz);
   assign p_rx = stick_prep(req.data.right_stick_x, cfg.right_dz);
   assign p_ry = stick_prep(req.data.right_stick_y, cfg.right_dz);
   assign p_lt = trig_prep(req.data.left_trigger,  cfg.trig_dz);
   assign p_rt = trig_prep(req.data.right_trigger, cfg.trig_dz);

   // Sequencer
   assign req.ready = (state_ff == ST_IDLE);
   assign accept    = req.valid && req.ready;
   assign step      = (state_ff == ST_RUN);
   assign out_free  = !rsp.valid || rsp.ready;
   assign load_out  = (state_ff == ST_DONE) && out_free;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(STEP_COUNT - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Capture buttons and half flags in pressed-vector order
   always_comb begin
      job_in = job_ff;
      if (accept) begin
         job_in.poll_valid = req.data.poll_valid;
         job_in.buttons    = req.data.raw_buttons;
         job_in.derived    = {p_rx.lo, p_rx.hi, p_ry.lo, p_ry.hi,
                              p_lx.lo, p_lx.hi, p_ly.lo, p_ly.hi,
                              p_rt.half, p_lt.half};
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   // Divider lanes
   gadc_lane u_lane_lx (.clock(clock), .start(accept), .step(step), .load(p_lx.load),
                        .scaled(s_lx));
   gadc_lane u_lane_ly (.clock(clock), .start(accept), .step(step), .load(p_ly.load),
                        .scaled(s_ly));
   gadc_lane u_lane_rx (.clock(clock), .start(accept), .step(step), .load(p_rx.load),
                        .scaled(s_rx));
   gadc_lane u_lane_ry (.clock(clock), .start(accept), .step(step), .load(p_ry.load),
                        .scaled(s_ry));
   gadc_lane u_lane_lt (.clock(clock), .start(accept), .step(step), .load(p_lt.load),
                        .scaled(s_lt));
   gadc_lane u_lane_rt (.clock(clock), .start(accept), .step(step), .load(p_rt.load),
                        .scaled(s_rt));

   gadc_merge u_merge (
      .clock   (clock),
      .reset   (reset),
      .load    (load_out),
      .job     (job_ff),
      .lane_lx (s_lx),
      .lane_ly (s_ly),
      .lane_rx (s_rx),
      .lane_ry (s_ry),
      .lane_lt (s_lt),
      .lane_rt (s_rt),
      .rsp     (rsp)
   );

endmodule

// ----- hdl/gadc_checker.sv -----
// Port-level checker for the deadzone conditioner, bound to the top level.
// Depends on gadc_pkg and gamepad_axis_deadzone_conditioner.
module gadc_checker
   import gadc_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // A stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // An accepted poll occupies the lanes for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("poll accepted while lanes busy");

   // An absent pad reports nothing
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.pad_present |-> rsp_data == '0)
      else $error("absent pad result not cleared");

   // Ignored button bits never show
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.pressed_now[11:10] == 2'b00
                    && rsp_data.pressed_before[11:10] == 2'b00)
      else $error("ignored button bits reported");

endmodule

bind gamepad_axis_deadzone_conditioner gadc_checker u_gadc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_data  (rsp.data)
);

// ----- tb/sv/tb_top.sv -----
// Testbench for the gamepad axis deadzone conditioner: drives polls, writes the
// deadzone registers over APB and checks every result beat against a predictor.
// Depends on gadc_pkg, gadc_if and the conditioner RTL.
`timescale 1ns / 100ps

module tb_top;
   import gadc_pkg::*;

   localparam int     IDLE_PERCENT   = 23;
   localparam int     RX_HOLD_CYCLES = 300;
   localparam int     DRAIN_CYCLES   = 40;
   localparam int     CYCLE_LIMIT    = 600000;
   localparam int     REPORT_LIMIT   = 10;
   localparam longint AXIS_FULL      = 32768;
   localparam longint TRIGGER_TOP    = 255;
   localparam logic [1:0] REG_UNUSED = 2'd3;

   logic clock;
   logic reset;

   gadc_req_if req_bus ();
   gadc_rsp_if rsp_bus ();

   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   // Deadzone settings as the block should hold them, and the last pressed vector
   cfg_type         dz_setting;
   logic [25:0]     pressed_history;
   rsp_payload_type expected_results [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int stall_requests;
   bit tx_steady;
   bit rx_steady;

   gamepad_axis_deadzone_conditioner dut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: end the run if it stalls
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // Rescale one stick axis and flag deflection past +half / -half
   function automatic logic [15:0] scale_axis(input logic signed [15:0] raw,
                                              input logic [14:0] dz,
                                              output logic past_pos,
                                              output logic past_neg);
      longint v, d, den, num, q;
      v = raw;
      d = dz;
      den = AXIS_FULL - d;
      q = 0;
      past_pos = 1'b0;
      past_neg = 1'b0;
      if (v > d) begin
         num = v - d;
         q = num * AXIS_FULL / den;
         past_pos = (2 * num > den);
      end else if (v < -d) begin
         num = v + d;
         q = -((-num) * AXIS_FULL / den);
         past_neg = (-2 * num > den);
      end
      return q[15:0];
   endfunction

   // Rescale one trigger; a threshold of full travel keeps it at zero
   function automatic logic [15:0] scale_trigger(input logic [7:0] raw,
                                                 input logic [7:0] tz,
                                                 output logic past_half);
      longint v, t, den, num, q;
      v = raw;
      t = tz;
      past_half = 1'b0;
      if (t >= TRIGGER_TOP || v < t) return 16'd0;
      den = TRIGGER_TOP - t;
      num = v - t;
      past_half = (2 * num > den);
      q = num * AXIS_FULL / den;
      return q[15:0];
   endfunction

   // Work out the result beat of one poll and advance the pressed history
   function automatic rsp_payload_type condition_poll(input req_payload_type p);
      rsp_payload_type r;
      logic l_up, l_down, l_right, l_left, r_up, r_down, r_right, r_left;
      logic lt_half, rt_half;
      logic [25:0] now;
      r = '0;
      if (!p.poll_valid) begin
         pressed_history = '0;
         return r;
      end
      r.left_x_scaled  = scale_axis(p.left_stick_x, dz_setting.left_dz, l_right, l_left);
      r.left_y_scaled  = scale_axis(p.left_stick_y, dz_setting.left_dz, l_up, l_down);
      r.right_x_scaled = scale_axis(p.right_stick_x, dz_setting.right_dz, r_right, r_left);
      r.right_y_scaled = scale_axis(p.right_stick_y, dz_setting.right_dz, r_up, r_down);
      r.left_trigger_scaled  = scale_trigger(p.left_trigger, dz_setting.trig_dz, lt_half);
      r.right_trigger_scaled = scale_trigger(p.right_trigger, dz_setting.trig_dz, rt_half);
      now = {r_left, r_right, r_down, r_up, l_left, l_right, l_down, l_up,
             rt_half, lt_half, p.raw_buttons & BTN_MASK};
      r.pad_present    = 1'b1;
      r.pressed_now    = now;
      r.pressed_before = pressed_history;
      pressed_history  = now;
      return r;
   endfunction

   function automatic req_payload_type make_poll(input logic valid, input logic [15:0] buttons,
                                                 input int lx, input int ly,
                                                 input int rx, input int ry,
                                                 input int lt, input int rt);
      req_payload_type p;
      p.poll_valid    = valid;
      p.raw_buttons   = buttons;
      p.left_stick_x  = lx[15:0];
      p.left_stick_y  = ly[15:0];
      p.right_stick_x = rx[15:0];
      p.right_stick_y = ry[15:0];
      p.left_trigger  = lt[7:0];
      p.right_trigger = rt[7:0];
      return p;
   endfunction

   // Stick value: deadzone edge, half point, inside it, extremes or anywhere
   function automatic logic [15:0] pick_axis(input logic [14:0] dz);
      int d, half_pt, v, mode;
      d = dz;
      half_pt = d + (32768 - d) / 2;
      mode = $urandom_range(0, 99);
      if (mode < 30) return 16'(int'($urandom_range(0, 65535)));
      if (mode < 88) begin
         if (mode < 50) v = d + int'($urandom_range(0, 6)) - 3;
         else if (mode < 70) v = half_pt + int'($urandom_range(0, 4)) - 2;
         else v = int'($urandom_range(0, d));
         if ($urandom_range(0, 1) == 1) v = -v;
      end else begin
         case ($urandom_range(0, 4))
            0: v = 32767;
            1: v = 32766;
            2: v = -32768;
            3: v = -32767;
            default: v = 0;
         endcase
      end
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic logic [7:0] pick_trigger(input logic [7:0] tz);
      int t, v, mode;
      t = tz;
      mode = $urandom_range(0, 99);
      if (mode < 40) v = int'($urandom_range(0, 255));
      else if (mode < 70) v = t + int'($urandom_range(0, 4)) - 2;
      else if (mode < 90) v = t + (255 - t) / 2 + int'($urandom_range(0, 2)) - 1;
      else v = ($urandom_range(0, 1) == 1) ? 255 : 0;
      if (v > 255) v = 255;
      if (v < 0) v = 0;
      return v[7:0];
   endfunction

   function automatic req_payload_type random_poll();
      req_payload_type p;
      p.poll_valid    = ($urandom_range(0, 99) >= 8);
      p.raw_buttons   = 16'($urandom_range(0, 65535));
      p.left_stick_x  = pick_axis(dz_setting.left_dz);
      p.left_stick_y  = pick_axis(dz_setting.left_dz);
      p.right_stick_x = pick_axis(dz_setting.right_dz);
      p.right_stick_y = pick_axis(dz_setting.right_dz);
      p.left_trigger  = pick_trigger(dz_setting.trig_dz);
      p.right_trigger = pick_trigger(dz_setting.trig_dz);
      return p;
   endfunction

   function automatic string describe(input rsp_payload_type r);
      return $sformatf("present=%0b now=%07h before=%07h lx=%04h ly=%04h rx=%04h ry=%04h lt=%04h rt=%04h",
                       r.pad_present, r.pressed_now, r.pressed_before,
                       r.left_x_scaled, r.left_y_scaled, r.right_x_scaled, r.right_y_scaled,
                       r.left_trigger_scaled, r.right_trigger_scaled);
   endfunction

   // Offer one poll beat, idling first at random; predict it once accepted
   task automatic send_poll(input req_payload_type p);
      while (!tx_steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data  <= p;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected_results.push_back(condition_poll(p));
   endtask

   // Drop valid and hold until every expected beat has come back
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // APB write: setup cycle, access cycle, then release the bus
   task automatic write_csr(input logic [1:0] index, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'({index, 2'b00});
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (index)
         REG_LEFT_DZ:  dz_setting.left_dz  = value[14:0];
         REG_RIGHT_DZ: dz_setting.right_dz = value[14:0];
         REG_TRIG_DZ:  dz_setting.trig_dz  = value[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic write_all(input logic [31:0] left_v, input logic [31:0] right_v,
                            input logic [31:0] trig_v);
      wait_idle();
      write_csr(REG_LEFT_DZ, left_v);
      write_csr(REG_RIGHT_DZ, right_v);
      write_csr(REG_TRIG_DZ, trig_v);
   endtask

   // Reset deadzones: edges, exact half points, invalid polls clearing history
   task automatic test_reset_values();
      send_poll(make_poll(1'b0, 16'hFFFF, -1, -1, -1, -1, 255, 255));
      send_poll(make_poll(1'b1, 16'hFFFF, 32767, -32768, -32768, 32767, 255, 0));
      send_poll(make_poll(1'b1, 16'h0000, 15698, -15698, 17379, -17379, 60, 59));
      send_poll(make_poll(1'b1, 16'h0C00, 24233, 24234, -25073, -25074, 157, 158));
      send_poll(make_poll(1'b1, 16'hF3FF, -15699, 15699, 17378, -17378, 61, 255));
      send_poll(make_poll(1'b0, 16'h0000, 0, 0, 0, 0, 0, 0));
      send_poll(make_poll(1'b1, 16'h5555, 0, 0, 0, 0, 0, 0));
   endtask

   // Zero and largest deadzones, over-wide writes, a write to an unused index
   task automatic test_deadzone_extremes();
      write_all(32'd0, 32'd0, 32'd0);
      send_poll(make_poll(1'b1, 16'hAAAA, 32767, -32768, 16384, 16385, 255, 0));
      send_poll(make_poll(1'b1, 16'h1234, -16384, -16385, 1, -1, 128, 127));
      // upper bits must be dropped: deadzones go to their largest values
      write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_poll(make_poll(1'b1, 16'hFFFF, 32767, -32767, -32768, 32766, 255, 255));
      send_poll(make_poll(1'b1, 16'h8001, -32768, 32767, 0, -32768, 0, 254));
      wait_idle();
      write_csr(REG_UNUSED, 32'h0000_1234);
      write_csr(REG_TRIG_DZ, 32'd254);
      send_poll(make_poll(1'b1, 16'h0F0F, -32768, -32768, -32768, -32768, 255, 254));
      send_poll(make_poll(1'b1, 16'hF0F0, 32767, 0, 32767, 0, 0, 253));
   endtask

   // Random polls over a run of deadzone settings, extremes included
   task automatic test_random_settings();
      int phase, n;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: write_all(32'd15698, 32'd17378, 32'd60);
            1: write_all(32'd0, 32'd0, 32'd0);
            2: write_all(32'd32767, 32'd32767, 32'd254);
            3: write_all(32'd1, 32'd32766, 32'd255);
            4: write_all(32'd16384, 32'd8000, 32'd128);
            default: write_all($urandom_range(0, 32767), $urandom_range(0, 32767),
                               $urandom_range(0, 255));
         endcase
         for (n = 0; n < 218; n++) begin
            // one long stretch with neither side idling
            tx_steady = (phase == 4 && n < 150);
            rx_steady = (phase == 4 && n < 150);
            send_poll(random_poll());
         end
      end
      tx_steady = 1'b0;
      rx_steady = 1'b0;
   endtask

   // Receiver holds off while polls keep coming, so the input must stall
   task automatic test_back_pressure();
      int n;
      tx_steady = 1'b1;
      stall_requests++;
      for (n = 0; n < 40; n++) send_poll(random_poll());
      tx_steady = 1'b0;
   endtask

   // Result side ready: random idling, plus long hold-offs on request
   initial begin
      int stall_left;
      int stalls_served;
      stall_left = 0;
      stalls_served = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stalls_served != stall_requests) begin
            stalls_served++;
            stall_left = RX_HOLD_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (rx_steady) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Compare each result beat with the oldest prediction
   always @(posedge clock) begin
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("unexpected result beat: %s", describe(rsp_bus.data));
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.data.pad_present !== want.pad_present ||
                rsp_bus.data.pressed_now !== want.pressed_now ||
                rsp_bus.data.pressed_before !== want.pressed_before ||
                rsp_bus.data.left_x_scaled !== want.left_x_scaled ||
                rsp_bus.data.left_y_scaled !== want.left_y_scaled ||
                rsp_bus.data.right_x_scaled !== want.right_x_scaled ||
                rsp_bus.data.right_y_scaled !== want.right_y_scaled ||
                rsp_bus.data.left_trigger_scaled !== want.left_trigger_scaled ||
                rsp_bus.data.right_trigger_scaled !== want.right_trigger_scaled) begin
               if (mismatch_count < REPORT_LIMIT) begin
                  $display("result mismatch, expected %s", describe(want));
                  $display("                 actual   %s", describe(rsp_bus.data));
               end
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.data    = '0;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      tx_steady       = 1'b0;
      rx_steady       = 1'b0;
      stall_requests  = 0;
      pressed_history = '0;
      dz_setting      = '{left_dz: LEFT_DZ_RESET, right_dz: RIGHT_DZ_RESET,
                          trig_dz: TRIG_DZ_RESET};
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_values();
      test_deadzone_extremes();
      test_random_settings();
      test_back_pressure();

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/gadc_pkg.sv
hdl/gadc_if.sv
hdl/gadc_csr.sv
hdl/gadc_lane.sv
hdl/gadc_merge.sv
hdl/gamepad_axis_deadzone_conditioner.sv
hdl/gadc_checker.sv
tb/sv/tb_top.sv
